@@ sv/ccr_pkg.sv @@
// shared constants, types and datapath operation codes for the clock-counter cache
// no dependencies
package ccr_pkg;

    localparam int ENTRIES   = 64;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int LIVE_W    = IDX_W + 1;
    localparam int CNT_W     = 4;
    localparam int KEY_W     = 32;
    localparam int SIZE_W    = 24;
    localparam int BYTE_W    = 32;
    localparam int EV_W      = 7;
    localparam int TALLY_W   = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT = 1'd1;
    localparam logic [BYTE_W-1:0]    CAP_RESET     = 32'd1048576;
    localparam logic [CNT_W-1:0]     MAX_RESET     = 4'd15;

    typedef logic [3:0] op_t;

    localparam op_t OP_NONE   = 4'd0;
    localparam op_t OP_ACCEPT = 4'd1;
    localparam op_t OP_START  = 4'd2;
    localparam op_t OP_LK_CMP = 4'd3;
    localparam op_t OP_HIT    = 4'd4;
    localparam op_t OP_RESIZE = 4'd5;
    localparam op_t OP_EV_CHK = 4'd6;
    localparam op_t OP_SW_CHK = 4'd7;
    localparam op_t OP_VIC    = 4'd8;
    localparam op_t OP_FREE   = 4'd9;
    localparam op_t OP_INS1   = 4'd10;
    localparam op_t OP_INS2   = 4'd11;
    localparam op_t OP_DONE   = 4'd12;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic reject;
        logic found;
        logic size_match;
        logic scan_last;
        logic must_evict;
        logic sweep_more;
        logic cnt_zero;
        logic free_here;
        logic live_zero;
        logic out_free;
    } stat_t;

endpackage

@@ sv/ccr_req_if.sv @@
// request channel: valid/ready plus key, size and warmup flag
// depends on ccr_pkg
interface ccr_req_if;
    logic                         valid;
    logic                         ready;
    logic [ccr_pkg::KEY_W-1:0]    object_key;
    logic [ccr_pkg::SIZE_W-1:0]   object_size;
    logic                         warmup;

    modport source (output valid, object_key, object_size, warmup, input ready);
    modport sink   (input valid, object_key, object_size, warmup, output ready);
endinterface

@@ sv/ccr_rsp_if.sv @@
// response channel: valid/ready plus outcome flags, counts and tallies
// depends on ccr_pkg
interface ccr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic                          resized;
    logic                          rejected;
    logic [ccr_pkg::EV_W-1:0]      evictions;
    logic [ccr_pkg::EV_W-1:0]      forced_evictions;
    logic [ccr_pkg::BYTE_W-1:0]    bytes_in_use;
    logic [ccr_pkg::TALLY_W-1:0]   total_accesses;
    logic [ccr_pkg::TALLY_W-1:0]   total_hits;
    logic [ccr_pkg::TALLY_W-1:0]   total_forced;

    modport source (output valid, hit, resized, rejected, evictions, forced_evictions,
                    bytes_in_use, total_accesses, total_hits, total_forced, input ready);
    modport sink   (input valid, hit, resized, rejected, evictions, forced_evictions,
                    bytes_in_use, total_accesses, total_hits, total_forced, output ready);
endinterface

@@ sv/ccr_ctrl.sv @@
// sequencer for lookup, clock sweep, eviction and insert
// depends on ccr_pkg
module ccr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ccr_pkg::stat_t stat,
    output ccr_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_START    = 4'd1;
    localparam logic [3:0] S_LK_WAIT  = 4'd2;
    localparam logic [3:0] S_LK_CMP   = 4'd3;
    localparam logic [3:0] S_HIT      = 4'd4;
    localparam logic [3:0] S_RESIZE   = 4'd5;
    localparam logic [3:0] S_EV_CHK   = 4'd6;
    localparam logic [3:0] S_SW_WAIT  = 4'd7;
    localparam logic [3:0] S_SW_CHK   = 4'd8;
    localparam logic [3:0] S_VIC_WAIT = 4'd9;
    localparam logic [3:0] S_VIC      = 4'd10;
    localparam logic [3:0] S_FREE     = 4'd11;
    localparam logic [3:0] S_INS_WAIT = 4'd12;
    localparam logic [3:0] S_INS1     = 4'd13;
    localparam logic [3:0] S_INS2     = 4'd14;
    localparam logic [3:0] S_DONE     = 4'd15;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = ccr_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = ccr_pkg::OP_ACCEPT;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.op     = ccr_pkg::OP_START;
                state_next = stat.reject ? S_DONE : S_LK_WAIT;
            end
            S_LK_WAIT:
            begin
                state_next = S_LK_CMP;
            end
            S_LK_CMP:
            begin
                cmd.op = ccr_pkg::OP_LK_CMP;
                if (stat.found && stat.size_match)
                    state_next = S_HIT;
                else if (stat.found)
                    state_next = S_RESIZE;
                else if (stat.scan_last)
                    state_next = S_EV_CHK;
                else
                    state_next = S_LK_WAIT;
            end
            S_HIT:
            begin
                cmd.op     = ccr_pkg::OP_HIT;
                state_next = S_DONE;
            end
            S_RESIZE:
            begin
                cmd.op     = ccr_pkg::OP_RESIZE;
                state_next = S_EV_CHK;
            end
            S_EV_CHK:
            begin
                cmd.op     = ccr_pkg::OP_EV_CHK;
                state_next = stat.must_evict ? S_SW_WAIT : S_FREE;
            end
            S_SW_WAIT:
            begin
                state_next = S_SW_CHK;
            end
            S_SW_CHK:
            begin
                cmd.op = ccr_pkg::OP_SW_CHK;
                if (!stat.sweep_more)
                    state_next = S_VIC_WAIT;
                else if (stat.cnt_zero)
                    state_next = S_VIC;
                else
                    state_next = S_SW_WAIT;
            end
            S_VIC_WAIT:
            begin
                state_next = S_VIC;
            end
            S_VIC:
            begin
                cmd.op     = ccr_pkg::OP_VIC;
                state_next = S_EV_CHK;
            end
            S_FREE:
            begin
                cmd.op = ccr_pkg::OP_FREE;
                if (stat.free_here)
                    state_next = S_INS_WAIT;
            end
            S_INS_WAIT:
            begin
                state_next = S_INS1;
            end
            S_INS1:
            begin
                cmd.op     = ccr_pkg::OP_INS1;
                state_next = stat.live_zero ? S_DONE : S_INS2;
            end
            S_INS2:
            begin
                cmd.op     = ccr_pkg::OP_INS2;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.op = ccr_pkg::OP_DONE;
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/ccr_dp.sv @@
// datapath: slot memories, ring links, hand, byte total, tallies, result register
// depends on ccr_pkg
module ccr_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ccr_pkg::cmd_t                   cmd,
    output ccr_pkg::stat_t                  stat,
    input  logic                            cfg_we,
    input  logic [ccr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ccr_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic [ccr_pkg::KEY_W-1:0]       in_key,
    input  logic [ccr_pkg::SIZE_W-1:0]      in_size,
    input  logic                            in_warmup,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_hit,
    output logic                            out_resized,
    output logic                            out_rejected,
    output logic [ccr_pkg::EV_W-1:0]        out_evictions,
    output logic [ccr_pkg::EV_W-1:0]        out_forced,
    output logic [ccr_pkg::BYTE_W-1:0]      out_bytes,
    output logic [ccr_pkg::TALLY_W-1:0]     out_accesses,
    output logic [ccr_pkg::TALLY_W-1:0]     out_hits,
    output logic [ccr_pkg::TALLY_W-1:0]     out_forced_total
);

    localparam int IW = ccr_pkg::IDX_W;
    localparam int LW = ccr_pkg::LIVE_W;
    localparam int CW = ccr_pkg::CNT_W;
    localparam int EW = ccr_pkg::EV_W;
    localparam int TW = ccr_pkg::TALLY_W;
    localparam int BW = ccr_pkg::BYTE_W;
    localparam int SW = ccr_pkg::SIZE_W;
    localparam int N  = ccr_pkg::ENTRIES;

    // slot memories, read at ptr every cycle
    logic [ccr_pkg::KEY_W-1:0] key_mem  [N];
    logic [SW-1:0]             size_mem [N];
    logic [CW-1:0]             cnt_mem  [N];
    logic [IW-1:0]             next_mem [N];
    logic [IW-1:0]             prev_mem [N];

    logic [ccr_pkg::KEY_W-1:0] key_rd_reg;
    logic [SW-1:0]             size_rd_reg;
    logic [CW-1:0]             cnt_rd_reg;
    logic [IW-1:0]             next_rd_reg;
    logic [IW-1:0]             prev_rd_reg;

    logic [BW-1:0]  cap_reg;
    logic [CW-1:0]  max_reg;
    logic [N-1:0]   valid_reg, valid_next;
    logic [IW-1:0]  hand_reg, hand_next;
    logic [IW-1:0]  ptr_reg, ptr_next;
    logic [IW-1:0]  slot_reg, slot_next;
    logic [LW-1:0]  live_reg, live_next;
    logic [LW-1:0]  sweep_reg, sweep_next;
    logic [BW-1:0]  bytes_reg, bytes_next;
    logic           once_reg, once_next;
    logic           forced_flag_reg, forced_flag_next;
    logic [TW-1:0]  acc_reg, acc_next;
    logic [TW-1:0]  hits_reg, hits_next;
    logic [TW-1:0]  ftal_reg, ftal_next;
    logic [ccr_pkg::KEY_W-1:0] key_reg;
    logic [SW-1:0]  size_reg;
    logic           warm_reg;
    logic           hit_reg, hit_next;
    logic           resized_reg, resized_next;
    logic           rej_reg, rej_next;
    logic [EW-1:0]  ev_reg, ev_next;
    logic [EW-1:0]  fev_reg, fev_next;
    logic           out_valid_reg, out_valid_next;

    logic           key_we, cnt_we, next_we, prev_we;
    logic [IW-1:0]  cnt_wa, next_wa, prev_wa;
    logic [CW-1:0]  cnt_wd;
    logic [IW-1:0]  next_wd, prev_wd;

    logic           unlink;
    logic           fits_not;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[slot_reg]  <= key_reg;
            size_mem[slot_reg] <= size_reg;
        end
        if (cnt_we)
            cnt_mem[cnt_wa] <= cnt_wd;
        if (next_we)
            next_mem[next_wa] <= next_wd;
        if (prev_we)
            prev_mem[prev_wa] <= prev_wd;
        key_rd_reg  <= key_mem[ptr_reg];
        size_rd_reg <= size_mem[ptr_reg];
        cnt_rd_reg  <= cnt_mem[ptr_reg];
        next_rd_reg <= next_mem[ptr_reg];
        prev_rd_reg <= prev_mem[ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == ccr_pkg::OP_ACCEPT)
        begin
            key_reg  <= in_key;
            size_reg <= in_size;
            warm_reg <= in_warmup;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg         <= ccr_pkg::CAP_RESET;
            max_reg         <= ccr_pkg::MAX_RESET;
            valid_reg       <= '0;
            hand_reg        <= '0;
            ptr_reg         <= '0;
            slot_reg        <= '0;
            live_reg        <= '0;
            sweep_reg       <= '0;
            bytes_reg       <= '0;
            once_reg        <= 1'b0;
            forced_flag_reg <= 1'b0;
            acc_reg         <= '0;
            hits_reg        <= '0;
            ftal_reg        <= '0;
            hit_reg         <= 1'b0;
            resized_reg     <= 1'b0;
            rej_reg         <= 1'b0;
            ev_reg          <= '0;
            fev_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == ccr_pkg::CFG_CAPACITY)
                cap_reg <= cfg_data;
            if (cfg_we && cfg_index == ccr_pkg::CFG_MAX_COUNT)
                max_reg <= cfg_data[CW-1:0];
            valid_reg       <= valid_next;
            hand_reg        <= hand_next;
            ptr_reg         <= ptr_next;
            slot_reg        <= slot_next;
            live_reg        <= live_next;
            sweep_reg       <= sweep_next;
            bytes_reg       <= bytes_next;
            once_reg        <= once_next;
            forced_flag_reg <= forced_flag_next;
            acc_reg         <= acc_next;
            hits_reg        <= hits_next;
            ftal_reg        <= ftal_next;
            hit_reg         <= hit_next;
            resized_reg     <= resized_next;
            rej_reg         <= rej_next;
            ev_reg          <= ev_next;
            fev_reg         <= fev_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result register, loaded when the sequence ends
    always_ff @(posedge clk)
    begin
        if (cmd.op == ccr_pkg::OP_DONE && stat.out_free)
        begin
            out_hit          <= hit_reg;
            out_resized      <= resized_reg;
            out_rejected     <= rej_reg;
            out_evictions    <= ev_reg;
            out_forced       <= fev_reg;
            out_bytes        <= bytes_reg;
            out_accesses     <= acc_reg;
            out_hits         <= hits_reg;
            out_forced_total <= ftal_reg;
        end
    end

    assign out_valid = out_valid_reg;

    assign fits_not = ({1'b0, bytes_reg} + {{(BW - SW + 1){1'b0}}, size_reg})
                      > {1'b0, cap_reg};

    always_comb
    begin
        stat.reject     = {{(BW - SW){1'b0}}, size_reg} > cap_reg;
        stat.found      = valid_reg[ptr_reg] && (key_rd_reg == key_reg);
        stat.size_match = (size_rd_reg == size_reg);
        stat.scan_last  = (ptr_reg == IW'(N - 1));
        stat.must_evict = (live_reg != '0) && (fits_not || live_reg >= LW'(N));
        stat.sweep_more = (sweep_reg < live_reg);
        stat.cnt_zero   = (cnt_rd_reg == '0);
        stat.free_here  = !valid_reg[ptr_reg];
        stat.live_zero  = (live_reg == '0);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        valid_next       = valid_reg;
        hand_next        = hand_reg;
        ptr_next         = ptr_reg;
        slot_next        = slot_reg;
        live_next        = live_reg;
        sweep_next       = sweep_reg;
        bytes_next       = bytes_reg;
        once_next        = once_reg;
        forced_flag_next = forced_flag_reg;
        acc_next         = acc_reg;
        hits_next        = hits_reg;
        ftal_next        = ftal_reg;
        hit_next         = hit_reg;
        resized_next     = resized_reg;
        rej_next         = rej_reg;
        ev_next          = ev_reg;
        fev_next         = fev_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        key_we           = 1'b0;
        cnt_we           = 1'b0;
        next_we          = 1'b0;
        prev_we          = 1'b0;
        cnt_wa           = ptr_reg;
        cnt_wd           = max_reg;
        next_wa          = prev_rd_reg;
        next_wd          = next_rd_reg;
        prev_wa          = next_rd_reg;
        prev_wd          = prev_rd_reg;
        unlink           = 1'b0;

        case (cmd.op)
            ccr_pkg::OP_START:
            begin
                hit_next     = 1'b0;
                resized_next = 1'b0;
                rej_next     = stat.reject;
                ev_next      = '0;
                fev_next     = '0;
                ptr_next     = '0;
                if (!stat.reject && !warm_reg)
                    acc_next = acc_reg + 1'b1;
            end
            ccr_pkg::OP_LK_CMP:
            begin
                if (!stat.found && !stat.scan_last)
                    ptr_next = ptr_reg + 1'b1;
            end
            ccr_pkg::OP_HIT:
            begin
                hit_next = 1'b1;
                cnt_we   = 1'b1;
                if (!warm_reg)
                    hits_next = hits_reg + 1'b1;
            end
            ccr_pkg::OP_RESIZE:
            begin
                resized_next = 1'b1;
                unlink       = 1'b1;
                if (hand_reg == ptr_reg)
                    hand_next = next_rd_reg;
            end
            ccr_pkg::OP_EV_CHK:
            begin
                sweep_next = '0;
                if (stat.must_evict)
                begin
                    once_next = 1'b1;
                    ptr_next  = hand_reg;
                end
                else
                begin
                    ptr_next = '0;
                end
            end
            ccr_pkg::OP_SW_CHK:
            begin
                if (!stat.sweep_more)
                begin
                    // full lap without a zero counter
                    forced_flag_next = 1'b1;
                    ptr_next         = hand_reg;
                end
                else if (stat.cnt_zero)
                begin
                    forced_flag_next = 1'b0;
                end
                else
                begin
                    cnt_we     = 1'b1;
                    cnt_wd     = cnt_rd_reg - 1'b1;
                    ptr_next   = next_rd_reg;
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ccr_pkg::OP_VIC:
            begin
                unlink    = 1'b1;
                hand_next = next_rd_reg;
                if (ev_reg != '1)
                    ev_next = ev_reg + 1'b1;
                if (forced_flag_reg)
                begin
                    if (fev_reg != '1)
                        fev_next = fev_reg + 1'b1;
                    if (!warm_reg)
                        ftal_next = ftal_reg + 1'b1;
                end
            end
            ccr_pkg::OP_FREE:
            begin
                if (stat.free_here)
                begin
                    slot_next = ptr_reg;
                    ptr_next  = hand_reg;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ccr_pkg::OP_INS1:
            begin
                key_we               = 1'b1;
                cnt_we               = 1'b1;
                cnt_wa               = slot_reg;
                cnt_wd               = once_reg ? max_reg : '0;
                valid_next[slot_reg] = 1'b1;
                live_next            = live_reg + 1'b1;
                bytes_next           = bytes_reg + {{(BW - SW){1'b0}}, size_reg};
                next_we              = 1'b1;
                prev_we              = 1'b1;
                next_wa              = slot_reg;
                prev_wa              = slot_reg;
                if (stat.live_zero)
                begin
                    next_wd   = slot_reg;
                    prev_wd   = slot_reg;
                    hand_next = slot_reg;
                end
                else
                begin
                    // new entry sits just before the hand
                    next_wd = hand_reg;
                    prev_wd = prev_rd_reg;
                end
            end
            ccr_pkg::OP_INS2:
            begin
                next_we = 1'b1;
                prev_we = 1'b1;
                next_wa = prev_rd_reg;
                next_wd = slot_reg;
                prev_wa = hand_reg;
                prev_wd = slot_reg;
            end
            ccr_pkg::OP_DONE:
            begin
                if (stat.out_free)
                    out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        // remove the slot at ptr from the ring
        if (unlink)
        begin
            next_we             = 1'b1;
            prev_we             = 1'b1;
            valid_next[ptr_reg] = 1'b0;
            live_next           = live_reg - 1'b1;
            bytes_next          = bytes_reg - {{(BW - SW){1'b0}}, size_rd_reg};
        end
    end

endmodule

@@ sv/clock_counter_cache_replacement.sv @@
// clock cache replacement with multi-bit counters, 64-slot ring
// key lookup visits up to 64 slots, each through a wait and a compare state; a hit then ends
// via the hit and done states; a miss adds a wait and a check per counter visited, a check and
// a victim step per eviction, a free-slot scan of up to 64 slots, then insert and result states
// throughput: one request at a time; the next is taken once the result is registered
// reset clears valid bits, hand, live count, byte total and tallies at once; no clearing pass
module clock_counter_cache_replacement (
    input  logic                            clk,
    input  logic                            rst_n,
    ccr_req_if.sink                         req,
    ccr_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [ccr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ccr_pkg::CFG_DAT_W-1:0]   cfg_data
);

    ccr_pkg::cmd_t  cmd;
    ccr_pkg::stat_t stat;
    logic           in_ready;

    assign req.ready = in_ready;

    ccr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ccr_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_key           (req.object_key),
        .in_size          (req.object_size),
        .in_warmup        (req.warmup),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .out_hit          (rsp.hit),
        .out_resized      (rsp.resized),
        .out_rejected     (rsp.rejected),
        .out_evictions    (rsp.evictions),
        .out_forced       (rsp.forced_evictions),
        .out_bytes        (rsp.bytes_in_use),
        .out_accesses     (rsp.total_accesses),
        .out_hits         (rsp.total_hits),
        .out_forced_total (rsp.total_forced)
    );

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.rejected |-> !rsp.hit && !rsp.resized && rsp.evictions == '0)
        else $error("rejected request reports other activity");

    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.hit |-> !rsp.resized && rsp.evictions == '0)
        else $error("hit reports resize or eviction");

    a_forced_le: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.forced_evictions <= rsp.evictions)
        else $error("forced evictions exceed evictions");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("second request taken while one is in work");

endmodule

@@ verif/clock_counter_cache_replacement_tb.sv @@
// self-checking bench for the clock-counter cache replacement block
// depends on ccr_pkg, ccr_req_if, ccr_rsp_if and clock_counter_cache_replacement
module clock_counter_cache_replacement_tb;

    localparam int WATCH_LIMIT = 200000;
    localparam int N_PHASE     = 6;

    typedef struct packed {
        logic                           hit;
        logic                           resized;
        logic                           rejected;
        logic [ccr_pkg::EV_W-1:0]       evictions;
        logic [ccr_pkg::EV_W-1:0]       forced_evictions;
        logic [ccr_pkg::BYTE_W-1:0]     bytes_in_use;
        logic [ccr_pkg::TALLY_W-1:0]    total_accesses;
        logic [ccr_pkg::TALLY_W-1:0]    total_hits;
        logic [ccr_pkg::TALLY_W-1:0]    total_forced;
    } outcome_t;

    typedef struct packed {
        logic [ccr_pkg::KEY_W-1:0]      key;
        logic [ccr_pkg::SIZE_W-1:0]     size;
        logic                           warm;
        logic                           typed;
        logic                           t_hit;
        logic                           t_resized;
        logic                           t_rejected;
        logic [ccr_pkg::BYTE_W-1:0]     t_bytes;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ccr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ccr_pkg::CFG_DAT_W-1:0] cfg_data;

    ccr_req_if req_ch ();
    ccr_rsp_if rsp_ch ();

    clock_counter_cache_replacement DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow cache state
    logic [ccr_pkg::KEY_W-1:0]   sh_key   [ccr_pkg::ENTRIES];
    logic [ccr_pkg::SIZE_W-1:0]  sh_size  [ccr_pkg::ENTRIES];
    logic [ccr_pkg::CNT_W-1:0]   sh_cnt   [ccr_pkg::ENTRIES];
    logic                        sh_valid [ccr_pkg::ENTRIES];
    int                          sh_next  [ccr_pkg::ENTRIES];
    int                          sh_prev  [ccr_pkg::ENTRIES];
    int                          sh_hand;
    int                          sh_live;
    logic [ccr_pkg::BYTE_W-1:0]  sh_bytes;
    logic                        sh_evicted_once;
    logic [ccr_pkg::TALLY_W-1:0] sh_acc, sh_hits, sh_forced;
    logic [ccr_pkg::BYTE_W-1:0]  sh_capacity;
    logic [ccr_pkg::CNT_W-1:0]   sh_max;

    outcome_t pending_outcomes [$];
    int  errors;
    int  stall;
    int  quiet_cycles;
    bit  calm;

    always #5 clk = ~clk;

    task automatic drop_slot(input int s);
        sh_next[sh_prev[s]] = sh_next[s];
        sh_prev[sh_next[s]] = sh_prev[s];
        sh_valid[s] = 1'b0;
        sh_live--;
        sh_bytes -= 32'(sh_size[s]);
    endtask

    // one clock sweep, returns 1 when no zero counter was found in a lap
    task automatic sweep_evict(output bit was_forced);
        int p;
        int victim;
        int nxt;
        bit found;
        p = sh_hand;
        victim = sh_hand;
        found = 1'b0;
        for (int i = 0; i < sh_live; i++)
        begin
            if (sh_cnt[p] == '0)
            begin
                victim = p;
                found = 1'b1;
                break;
            end
            sh_cnt[p] = sh_cnt[p] - 1'b1;
            p = sh_next[p];
        end
        nxt = sh_next[victim];
        drop_slot(victim);
        sh_hand = nxt;
        was_forced = !found;
    endtask

    task automatic cache_lookup(input logic [ccr_pkg::KEY_W-1:0] key,
                                input logic [ccr_pkg::SIZE_W-1:0] size,
                                input logic warm, output outcome_t r);
        int idx;
        int s;
        int p;
        bit present;
        bit was_forced;
        r = '0;
        if (32'(size) > sh_capacity)
            r.rejected = 1'b1;
        else
        begin
            present = 1'b0;
            idx = 0;
            if (!warm)
                sh_acc++;
            for (int i = 0; i < ccr_pkg::ENTRIES; i++)
                if (!present && sh_valid[i] && sh_key[i] == key)
                begin
                    present = 1'b1;
                    idx = i;
                end
            if (present && sh_size[idx] == size)
            begin
                r.hit = 1'b1;
                if (!warm)
                    sh_hits++;
                sh_cnt[idx] = sh_max;
            end
            else
            begin
                if (present)
                begin
                    r.resized = 1'b1;
                    if (sh_hand == idx)
                        sh_hand = sh_next[idx];
                    drop_slot(idx);
                end
                while (sh_live > 0 && ({32'd0, sh_bytes} + 64'(size) > 64'(sh_capacity)
                                       || sh_live >= ccr_pkg::ENTRIES))
                begin
                    sh_evicted_once = 1'b1;
                    sweep_evict(was_forced);
                    if (was_forced)
                    begin
                        if (r.forced_evictions != 7'h7f)
                            r.forced_evictions++;
                        if (!warm)
                            sh_forced++;
                    end
                    if (r.evictions != 7'h7f)
                        r.evictions++;
                end
                s = -1;
                for (int i = 0; i < ccr_pkg::ENTRIES; i++)
                    if (s < 0 && !sh_valid[i])
                        s = i;
                sh_key[s] = key;
                sh_size[s] = size;
                sh_cnt[s] = sh_evicted_once ? sh_max : '0;
                sh_valid[s] = 1'b1;
                if (sh_live == 0)
                begin
                    sh_next[s] = s;
                    sh_prev[s] = s;
                    sh_hand = s;
                end
                else
                begin
                    p = sh_prev[sh_hand];
                    sh_next[s] = sh_hand;
                    sh_prev[s] = p;
                    sh_next[p] = s;
                    sh_prev[sh_hand] = s;
                end
                sh_live++;
                sh_bytes += 32'(size);
            end
        end
        r.bytes_in_use = sh_bytes;
        r.total_accesses = sh_acc;
        r.total_hits = sh_hits;
        r.total_forced = sh_forced;
    endtask

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
        begin
            $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
            errors++;
        end
    endtask

    task automatic write_reg(input logic [ccr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ccr_pkg::CFG_DAT_W-1:0] val);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == ccr_pkg::CFG_CAPACITY)
            sh_capacity = val;
        else
            sh_max = val[ccr_pkg::CNT_W-1:0];
    endtask

    // drive one request, hold until the transfer, then predict
    task automatic send_request(input logic [ccr_pkg::KEY_W-1:0] key,
                                input logic [ccr_pkg::SIZE_W-1:0] size,
                                input logic warm, output outcome_t r);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.object_key <= key;
        req_ch.object_size <= size;
        req_ch.warmup <= warm;
        do
            @(posedge clk);
        while (!req_ch.ready);
        cache_lookup(key, size, warm, r);
    endtask

    // result checker
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("unexpected result transfer at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                report("hit", 32'(rsp_ch.hit), 32'(want.hit));
                report("resized", 32'(rsp_ch.resized), 32'(want.resized));
                report("rejected", 32'(rsp_ch.rejected), 32'(want.rejected));
                report("evictions", 32'(rsp_ch.evictions), 32'(want.evictions));
                report("forced_evictions", 32'(rsp_ch.forced_evictions),
                       32'(want.forced_evictions));
                report("bytes_in_use", rsp_ch.bytes_in_use, want.bytes_in_use);
                report("total_accesses", rsp_ch.total_accesses, want.total_accesses);
                report("total_hits", rsp_ch.total_hits, want.total_hits);
                report("total_forced", rsp_ch.total_forced, want.total_forced);
            end
        end
    end

    // result-side stalls: ready is dropped at random in bursts, except in the calm phase
    always @(posedge clk)
    begin
        if (stall > 0)
        begin
            stall--;
            rsp_ch.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall = $urandom_range(0, 3);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("[clock_counter_cache_replacement] ERROR");
            $finish;
        end
    end

    initial
    begin
        plan_row_t plan [11];
        logic [ccr_pkg::BYTE_W-1:0] ph_cap  [N_PHASE];
        logic [ccr_pkg::CNT_W-1:0]  ph_max  [N_PHASE];
        int                         ph_pool [N_PHASE];
        int                         ph_smax [N_PHASE];
        outcome_t r;
        logic [ccr_pkg::KEY_W-1:0]  key;
        logic [ccr_pkg::SIZE_W-1:0] size;

        plan = '{
            '{32'h0000_0000, 24'd1,        1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd1},
            '{32'h0000_0000, 24'd1,        1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 32'd1},
            '{32'h0000_0000, 24'd2,        1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 32'd2},
            '{32'hffff_ffff, 24'hff_ffff,  1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 32'd2},
            '{32'hffff_ffff, 24'd1048576,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
            '{32'h0000_0001, 24'd0,        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
            '{32'haaaa_aaaa, 24'd1,        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
            '{32'h5555_5555, 24'd1048575,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
            '{32'h5555_5555, 24'd1048575,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
            '{32'h0000_0001, 24'd0,        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
            '{32'h0000_0000, 24'd1048577,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0}
        };
        ph_cap  = '{32'hffff_ffff, 32'd1, 32'd1000, 32'd100000, 32'd1048576, 32'd5000};
        ph_max  = '{4'd15, 4'd0, 4'd3, 4'd1, 4'd15, 4'd7};
        ph_pool = '{100, 8, 40, 120, 64, 30};
        ph_smax = '{16777215, 2, 300, 5000, 50000, 800};

        clk = 1'b0;
        errors = 0;
        stall = 0;
        quiet_cycles = 0;
        calm = 1'b0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= ccr_pkg::CFG_CAPACITY;
        cfg_data <= '0;
        req_ch.valid <= 1'b0;
        req_ch.object_key <= '0;
        req_ch.object_size <= '0;
        req_ch.warmup <= 1'b0;
        sh_hand = 0;
        sh_live = 0;
        sh_bytes = '0;
        sh_evicted_once = 1'b0;
        sh_acc = '0;
        sh_hits = '0;
        sh_forced = '0;
        sh_capacity = ccr_pkg::CAP_RESET;
        sh_max = ccr_pkg::MAX_RESET;
        for (int i = 0; i < ccr_pkg::ENTRIES; i++)
            sh_valid[i] = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            send_request(plan[i].key, plan[i].size, plan[i].warm, r);
            if (plan[i].typed)
            begin
                r.hit = plan[i].t_hit;
                r.resized = plan[i].t_resized;
                r.rejected = plan[i].t_rejected;
                r.bytes_in_use = plan[i].t_bytes;
            end
            pending_outcomes.push_back(r);
        end
        req_ch.valid <= 1'b0;

        for (int ph = 0; ph < N_PHASE; ph++)
        begin
            write_reg(ccr_pkg::CFG_CAPACITY, ph_cap[ph]);
            write_reg(ccr_pkg::CFG_MAX_COUNT, ccr_pkg::CFG_DAT_W'(ph_max[ph]));
            calm = (ph == N_PHASE - 1);
            for (int n = 0; n < 255; n++)
            begin
                if ($urandom_range(0, 7) == 0)
                    key = $urandom;
                else
                    key = ccr_pkg::KEY_W'($urandom_range(0, ph_pool[ph] - 1));
                if ($urandom_range(0, 7) == 0)
                    size = ccr_pkg::SIZE_W'($urandom);
                else
                    size = ccr_pkg::SIZE_W'($urandom_range(0, ph_smax[ph]));
                send_request(key, size, $urandom_range(0, 3) == 0, r);
                pending_outcomes.push_back(r);
            end
            req_ch.valid <= 1'b0;
        end

        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("[clock_counter_cache_replacement] OK");
        else
            $display("[clock_counter_cache_replacement] ERROR");
        $finish;
    end
endmodule

@@ sim.f @@
sv/ccr_pkg.sv
sv/ccr_req_if.sv
sv/ccr_rsp_if.sv
sv/ccr_ctrl.sv
sv/ccr_dp.sv
sv/clock_counter_cache_replacement.sv
verif/clock_counter_cache_replacement_tb.sv
